@@ sv/gb3_pkg.sv @@
// Package with the constants, types and helper functions of the 3x3 Gaussian blur.
`timescale 1ns / 1ps
`default_nettype none

package gb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W   = 11;
  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
  localparam int KERN_W_BITS = 5;
  localparam int SUM_W   = 15;
  localparam int WSUM_W  = 7;
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W = 18;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_index_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } nbr_mask_t;

  localparam logic [2:0][2:0][KERN_W_BITS-1:0] KERN_W = {
    {5'd3,  5'd10, 5'd3},
    {5'd10, 5'd20, 5'd10},
    {5'd3,  5'd10, 5'd3}
  };

  localparam logic [RECIP_W-1:0] RECIP_20 = RECIP_W'(((1 << RECIP_SHIFT) + 19) / 20);
  localparam logic [RECIP_W-1:0] RECIP_30 = RECIP_W'(((1 << RECIP_SHIFT) + 29) / 30);
  localparam logic [RECIP_W-1:0] RECIP_40 = RECIP_W'(((1 << RECIP_SHIFT) + 39) / 40);
  localparam logic [RECIP_W-1:0] RECIP_43 = RECIP_W'(((1 << RECIP_SHIFT) + 42) / 43);
  localparam logic [RECIP_W-1:0] RECIP_56 = RECIP_W'(((1 << RECIP_SHIFT) + 55) / 56);
  localparam logic [RECIP_W-1:0] RECIP_72 = RECIP_W'(((1 << RECIP_SHIFT) + 71) / 72);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Reciprocal of the sum of the kernel weights that lie inside the image.
  function automatic logic [RECIP_W-1:0] recip_for(input nbr_mask_t m);
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic [WSUM_W-1:0] wsum;
    logic [RECIP_W-1:0] r;
    row_ok = {m.bottom, 1'b1, m.top};
    col_ok = {m.right, 1'b1, m.left};
    wsum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_ok[i] && col_ok[j]) begin
          wsum = wsum + WSUM_W'(KERN_W[i][j]);
        end
      end
    end
    case (wsum)
      7'd20:   r = RECIP_20;
      7'd30:   r = RECIP_30;
      7'd40:   r = RECIP_40;
      7'd43:   r = RECIP_43;
      7'd56:   r = RECIP_56;
      default: r = RECIP_72;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/gaussian_blur_3x3_border_renorm.sv @@
// Top level of the streaming 3x3 Gaussian blur with border renormalisation.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   in_pixel_value
//   out      out_valid / out_ready out_blurred_value, out_frame_end
//   cfg      cfg_we                cfg_index, cfg_data
//
// One transaction is accepted per cycle unless back-pressure holds the pipeline; each result
// passes the line store read, window update, weighted sum and reciprocal multiply registers.
// The two line stores are read through a register, and a multiplier stage replaces the
// division by the weight sum.
// Reset is synchronous and active low; the line stores are not cleared.
// Each stage holds its item while the next is full and stalled, so bubbles are absorbed.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_3x3_border_renorm (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [gb3_pkg::PIX_W-1:0]     in_pixel_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [gb3_pkg::PIX_W-1:0]          out_blurred_value,
  output logic                               out_frame_end,
  input  wire logic                          cfg_we,
  input  wire logic [gb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gb3_pkg::DIM_W-1:0]     cfg_data
);

  import gb3_pkg::*;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  logic [DIM_W-1:0] image_width_r;
  logic [DIM_W-1:0] image_height_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic             in_acc;
  logic [COL_W-1:0] ic_cur;
  pixel_t           pix_in;
  logic             emit;
  logic [ROW_W-1:0] pr;
  logic [COL_W-1:0] pc;
  nbr_mask_t        mask;
  logic             last;
  logic [COL_W:0]   ic_inc;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;

  pixel_t           upper_mem [MAX_WIDTH];
  pixel_t           middle_mem [MAX_WIDTH];
  pixel_t           up_rd_r;
  pixel_t           mid_rd_r;

  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  pixel_t           s1_pix_r;
  logic             s1_emit_r;
  nbr_mask_t        s1_mask_r;
  logic             s1_last_r;
  logic             byp_r;
  pixel_t           byp_up_r;
  pixel_t           byp_mid_r;
  pixel_t           up_eff;
  pixel_t           mid_eff;

  window_t          window_r;
  logic             s2_valid_r;
  nbr_mask_t        s2_mask_r;
  logic             s2_last_r;
  logic [SUM_W-1:0] s2_sum;
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;

  logic                     s3_valid_r;
  logic [SUM_W-1:0]         s3_sum_r;
  logic [RECIP_W-1:0]       s3_recip_r;
  logic                     s3_last_r;
  logic [SUM_W+RECIP_W-1:0] prod;

  logic   out_valid_r;
  pixel_t out_blurred_value_r;
  logic   out_frame_end_r;

  logic out_free;
  logic s3_free;
  logic s3_adv;
  logic s2_free;
  logic s2_adv;
  logic s1_free;
  logic s1_adv;

  assign w = clamp_dim(image_width_r, MAX_W_DIM);
  assign h = clamp_dim(image_height_r, MAX_H_DIM);

  assign out_free = !out_valid_r || out_ready;
  assign s3_adv   = s3_valid_r && out_free;
  assign s3_free  = !s3_valid_r || out_free;
  assign s2_adv   = s2_valid_r && s3_free;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_adv   = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    ic_cur = ((COL_W + 1)'(col_r) >= (COL_W + 1)'(w)) ? '0 : col_r;
    pix_in = ((ROW_W + 1)'(row_r) < (ROW_W + 1)'(h)) ? in_pixel_value : '0;
    emit = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (ic_cur != '0));
    if (ic_cur != '0) begin
      pr = row_r - ROW_W'(1);
      pc = ic_cur - COL_W'(1);
    end else begin
      pr = row_r - ROW_W'(2);
      pc = COL_W'(w - DIM_W'(1));
    end
    mask.top    = (pr != '0);
    mask.bottom = ((ROW_W + 1)'(pr) + (ROW_W + 1)'(1)) < (ROW_W + 1)'(h);
    mask.left   = (pc != '0);
    mask.right  = ((COL_W + 1)'(pc) + (COL_W + 1)'(1)) < (COL_W + 1)'(w);
    last = emit && ((ROW_W + 1)'(pr) == (ROW_W + 1)'(h - DIM_W'(1)))
                && ((COL_W + 1)'(pc) == (COL_W + 1)'(w - DIM_W'(1)));
    ic_inc = (COL_W + 1)'(ic_cur) + (COL_W + 1)'(1);
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (ic_inc >= (COL_W + 1)'(w)) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = ic_inc[COL_W-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= MAX_W_DIM;
      image_height_r <= MAX_H_DIM;
      col_r          <= '0;
      row_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          image_width_r <= cfg_data;
          col_r         <= '0;
          row_r         <= '0;
        end
        CFG_IMAGE_HEIGHT: begin
          image_height_r <= cfg_data;
          col_r          <= '0;
          row_r          <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // The line stores are read when a transaction enters and written when it leaves stage one.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      up_rd_r  <= upper_mem[ic_cur];
      mid_rd_r <= middle_mem[ic_cur];
    end
    if (s1_adv) begin
      upper_mem[s1_col_r]  <= mid_eff;
      middle_mem[s1_col_r] <= s1_pix_r;
    end
  end

  assign up_eff  = byp_r ? byp_up_r : up_rd_r;
  assign mid_eff = byp_r ? byp_mid_r : mid_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // A write to the same column in the cycle of the read is forwarded.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r  <= ic_cur;
      s1_pix_r  <= pix_in;
      s1_emit_r <= emit;
      s1_mask_r <= mask;
      s1_last_r <= last;
      byp_r     <= s1_adv && (s1_col_r == ic_cur);
      byp_up_r  <= mid_eff;
      byp_mid_r <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= s1_emit_r;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        window_r[r][0] <= window_r[r][1];
        window_r[r][1] <= window_r[r][2];
      end
      window_r[0][2] <= up_eff;
      window_r[1][2] <= mid_eff;
      window_r[2][2] <= s1_pix_r;
      s2_mask_r      <= s1_mask_r;
      s2_last_r      <= s1_last_r;
    end
  end

  always_comb begin
    row_ok = {s2_mask_r.bottom, 1'b1, s2_mask_r.top};
    col_ok = {s2_mask_r.right, 1'b1, s2_mask_r.left};
    s2_sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          s2_sum = s2_sum + SUM_W'(window_r[r][c]) * SUM_W'(KERN_W[r][c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s3_valid_r <= 1'b1;
    end else if (s3_adv) begin
      s3_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_sum_r   <= s2_sum;
      s3_recip_r <= recip_for(s2_mask_r);
      s3_last_r  <= s2_last_r;
    end
  end

  assign prod = (SUM_W + RECIP_W)'(s3_sum_r) * (SUM_W + RECIP_W)'(s3_recip_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      out_blurred_value_r <= prod[RECIP_SHIFT +: PIX_W];
      out_frame_end_r     <= s3_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_blurred_value = out_blurred_value_r;
  assign out_frame_end     = out_frame_end_r;

endmodule

`default_nettype wire

@@ tb/gaussian_blur_3x3_border_renorm_tb.sv @@
// Self-checking testbench for the streaming 3x3 Gaussian blur with border renormalisation.
`timescale 1ns / 1ps

module gaussian_blur_3x3_border_renorm_tb;
  import gb3_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int DRAIN_CYCLES   = 8;
  localparam int STALL_LIMIT    = 4000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int IDLE_PERCENT   = 14;
  localparam int RANDOM_ITEMS   = 400;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIRECTED_ROWS  = 28;
  localparam int unsigned EDGE_ITEMS     = 60;
  localparam int unsigned ITEMS_UNCAPPED = 32'hFFFF_FFFF;

  typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_t;

  typedef struct {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [DIM_W-1:0]       data;
    pixel_t                 px;
    bit                     typed;
    pixel_t                 want_value;
    bit                     want_end;
  } directed_step_t;

  typedef struct {
    pixel_t value;
    logic   frame_end;
  } blur_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_blurred_value;
  logic                 out_frame_end;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;

  pixel_t           upper_row_mem [MAX_WIDTH];
  pixel_t           middle_row_mem [MAX_WIDTH];
  pixel_t           nbhd [9];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  int unsigned      in_col;
  int unsigned      in_row;
  int unsigned      results_in_frame;
  blur_result_t     blur_expected_q [$];

  int unsigned pixels_sent = 0;
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          squeeze_left = 0;
  bit          squeeze_go = 1'b0;
  bit          squeeze_done = 1'b0;
  bit          steady_run = 1'b0;

  directed_step_t directed_steps [DIRECTED_ROWS] = '{
    '{STEP_CFG,   CFG_IMAGE_WIDTH,  11'd1,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_CFG,   CFG_IMAGE_HEIGHT, 11'd1,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'hFF, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h0F, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'hF0, 1'b1, 8'hFF, 1'b1},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_CFG,   CFG_SPARE_2,      11'h7FF,  8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_CFG,   CFG_SPARE_3,      11'h555,  8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'hFF, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'hFF, 1'b1, 8'h00, 1'b1},
    '{STEP_CFG,   CFG_IMAGE_WIDTH,  11'd0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_CFG,   CFG_IMAGE_HEIGHT, 11'd0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h81, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h7E, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h00, 1'b1, 8'h81, 1'b1},
    '{STEP_CFG,   CFG_IMAGE_WIDTH,  11'd3,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_CFG,   CFG_IMAGE_HEIGHT, 11'd3,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'hFF, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_CFG,   CFG_IMAGE_WIDTH,  11'd2,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_CFG,   CFG_IMAGE_HEIGHT, 11'd2,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'hFF, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h80, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h7F, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h55, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'hAA, 1'b0, 8'h00, 1'b0},
    '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'h00, 1'b0, 8'h00, 1'b0}
  };

  gaussian_blur_3x3_border_renorm dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_value    (in_pixel_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_blurred_value (out_blurred_value),
    .out_frame_end     (out_frame_end),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned effective_dim(input logic [DIM_W-1:0] v,
                                                input int unsigned limit);
    if (v == '0) return 1;
    return (v > limit) ? limit : int'(v);
  endfunction

  function automatic int unsigned kernel_weight(input int r, input int c);
    if (r == 1 && c == 1) return 20;
    if (r == 1 || c == 1) return 10;
    return 3;
  endfunction

  function automatic void rewind_frame();
    in_col = 0;
    in_row = 0;
    results_in_frame = 0;
  endfunction

  // Advances the blur state by one transaction; returns 1 when it yields a result.
  function automatic bit blur_step(input pixel_t px, output blur_result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned pr;
    int unsigned pc;
    int unsigned sum;
    int unsigned wsum;
    pixel_t      pix;
    bit          row_ok;
    bit          col_ok;
    bit          produced;
    w = effective_dim(width_reg, MAX_WIDTH);
    h = effective_dim(height_reg, MAX_HEIGHT);
    produced = 1'b0;
    res.value = '0;
    res.frame_end = 1'b0;
    pix = (in_row < h) ? px : '0;
    for (int r = 0; r < 3; r++) begin
      nbhd[r * 3]     = nbhd[r * 3 + 1];
      nbhd[r * 3 + 1] = nbhd[r * 3 + 2];
    end
    nbhd[2] = upper_row_mem[in_col];
    nbhd[5] = middle_row_mem[in_col];
    nbhd[8] = pix;
    upper_row_mem[in_col]  = middle_row_mem[in_col];
    middle_row_mem[in_col] = pix;
    if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
      if (in_col >= 1) begin
        pr = in_row - 1;
        pc = in_col - 1;
      end else begin
        pr = in_row - 2;
        pc = w - 1;
      end
      sum = 0;
      wsum = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          row_ok = (r == 0) ? (pr >= 1) : (r == 2) ? (pr + 1 < h) : 1'b1;
          col_ok = (c == 0) ? (pc >= 1) : (c == 2) ? (pc + 1 < w) : 1'b1;
          if (row_ok && col_ok) begin
            sum += nbhd[r * 3 + c] * kernel_weight(r, c);
            wsum += kernel_weight(r, c);
          end
        end
      end
      res.value = pixel_t'(sum / wsum);
      res.frame_end = (results_in_frame == w * h - 1);
      produced = 1'b1;
      if (res.frame_end) begin
        rewind_frame();
        return produced;
      end
      results_in_frame++;
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    return produced;
  endfunction

  function automatic pixel_t random_pixel();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return pixel_t'($urandom_range(0, 255));
  endfunction

  task automatic settle_outputs();
    in_valid <= 1'b0;
    @(negedge clk);
    while (blur_expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] data);
    settle_outputs();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = data;
      rewind_frame();
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      height_reg = data;
      rewind_frame();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic offer_pixel(input pixel_t px, input bit typed, input pixel_t want_value,
                             input bit want_end);
    blur_result_t res;
    bit           produced;
    while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    produced = blur_step(px, res);
    if (typed) begin
      res.value = want_value;
      res.frame_end = want_end;
      produced = 1'b1;
    end
    if (produced) blur_expected_q.push_back(res);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Sends frames of one configuration, stopping early at max_items or on a random abort.
  task automatic run_phase(input logic [DIM_W-1:0] w_set, input logic [DIM_W-1:0] h_set,
                           input int frames, input bit allow_abort, input int squeeze_after,
                           input bit pause_midway, input int unsigned max_items);
    int unsigned w;
    int unsigned h;
    int unsigned frame_len;
    int unsigned stop_at;
    int unsigned sent;
    program_register(CFG_IMAGE_WIDTH, w_set);
    program_register(CFG_IMAGE_HEIGHT, h_set);
    w = effective_dim(w_set, MAX_WIDTH);
    h = effective_dim(h_set, MAX_HEIGHT);
    frame_len = w * h + w + 1;
    sent = 0;
    for (int f = 0; f < frames; f++) begin
      stop_at = frame_len;
      if (allow_abort && f == frames - 1 && $urandom_range(0, 5) == 0) begin
        stop_at = $urandom_range(1, frame_len - 1);
      end
      for (int unsigned i = 0; i < stop_at; i++) begin
        if (sent >= max_items) return;
        if (squeeze_after != 0 && i == squeeze_after) squeeze_go = 1'b1;
        if (pause_midway && f == 0 && i == frame_len / 2) settle_outputs();
        offer_pixel(random_pixel(), 1'b0, '0, 1'b0);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (squeeze_left > 0) begin
      out_ready <= 1'b0;
      squeeze_left <= squeeze_left - 1;
    end else if (squeeze_go && !squeeze_done) begin
      out_ready <= 1'b0;
      squeeze_left <= SQUEEZE_CYCLES - 1;
      squeeze_done <= 1'b1;
    end else begin
      out_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    blur_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (blur_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected transaction: value %0d frame_end %0d",
                   out_blurred_value, out_frame_end);
        end
      end else begin
        want = blur_expected_q.pop_front();
        if (out_blurred_value !== want.value || out_frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch: expected value %0d frame_end %0d, got value %0d frame_end %0d",
                     want.value, want.frame_end, out_blurred_value, out_frame_end);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned random_base;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    rewind_frame();
    foreach (nbhd[i]) nbhd[i] = '0;
    foreach (upper_row_mem[i]) begin
      upper_row_mem[i] = '0;
      middle_row_mem[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG) begin
        program_register(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        offer_pixel(directed_steps[i].px, directed_steps[i].typed,
                    directed_steps[i].want_value, directed_steps[i].want_end);
      end
    end

    run_phase(11'd5, 11'd4, 2, 1'b0, 0, 1'b1, ITEMS_UNCAPPED);
    steady_run = 1'b1;
    run_phase(11'd0, 11'd2047, 1, 1'b0, 20, 1'b0, EDGE_ITEMS);
    steady_run = 1'b0;
    run_phase(11'd2047, 11'd0, 1, 1'b0, 0, 1'b0, EDGE_ITEMS);

    random_base = pixels_sent;
    while (pixels_sent - random_base < RANDOM_ITEMS) begin
      run_phase(($urandom_range(0, 9) == 0) ? 11'($urandom_range(13, 40))
                                            : 11'($urandom_range(1, 12)),
                11'($urandom_range(1, 8)), $urandom_range(1, 3), 1'b1, 0, 1'b0,
                RANDOM_ITEMS - (pixels_sent - random_base));
    end

    settle_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
